// File: hdl/bdisz_pkg.sv
// Shared types, constants and element checks for the BDI line size unit
package bdisz_pkg;

  // line geometry
  localparam int WORDS_PER_LINE = 8;
  localparam int COUNT_W        = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int LINE_BYTES     = 8 * WORDS_PER_LINE;
  localparam int SIZE_W         = 8;

  // two-base delta modes, grouped by element width
  localparam int N64   = 3;
  localparam int N32   = 2;
  localparam int MODES = 6;

  localparam int MODE_B8_D1 = 0;
  localparam int MODE_B8_D2 = 1;
  localparam int MODE_B8_D4 = 2;
  localparam int MODE_B4_D1 = 3;
  localparam int MODE_B4_D2 = 4;
  localparam int MODE_B2_D1 = 5;

  // delta limits per mode
  localparam logic [63:0] LIM64 [N64] = '{64'hFF, 64'hFFFF, 64'hFFFF_FFFF};
  localparam logic [31:0] LIM32 [N32] = '{32'hFF, 32'hFFFF};
  localparam logic [15:0] LIM16       = 16'hFF;

  // encoded size per mode: delta bytes * element count + two bases
  localparam logic [SIZE_W-1:0] SIZE_MODE [MODES] = '{
    SIZE_W'(1 * WORDS_PER_LINE + 16),
    SIZE_W'(2 * WORDS_PER_LINE + 16),
    SIZE_W'(4 * WORDS_PER_LINE + 16),
    SIZE_W'(1 * 2 * WORDS_PER_LINE + 8),
    SIZE_W'(2 * 2 * WORDS_PER_LINE + 8),
    SIZE_W'(1 * 4 * WORDS_PER_LINE + 4)
  };

  // per-mode tracking state
  typedef struct packed {
    logic [63:0] base;
    logic        found;
    logic        covered;
  } mode64_t;

  typedef struct packed {
    logic [31:0] base;
    logic        found;
    logic        covered;
  } mode32_t;

  typedef struct packed {
    logic [15:0] base;
    logic        found;
    logic        covered;
  } mode16_t;

  // line status after the current word
  typedef struct packed {
    logic             all_zero;
    logic             same_word;
    logic             same_half;
    logic [MODES-1:0] covered;
  } line_flags_t;

  // wrapped 64-bit distance, read as signed, within limit
  function automatic logic near64(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [63:0] d;
    logic [63:0] mag;
    d   = a - b;
    mag = d[63] ? (~d + 64'd1) : d;
    return mag <= lim;
  endfunction

  // exact 32-bit distance within limit
  function automatic logic near32(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
    logic [32:0] d;
    logic [32:0] mag;
    d   = {1'b0, a} - {1'b0, b};
    mag = d[32] ? (~d + 33'd1) : d;
    return mag <= {1'b0, lim};
  endfunction

  // exact 16-bit distance within limit
  function automatic logic near16(logic [15:0] a, logic [15:0] b, logic [15:0] lim);
    logic [16:0] d;
    logic [16:0] mag;
    d   = {1'b0, a} - {1'b0, b};
    mag = d[16] ? (~d + 17'd1) : d;
    return mag <= {1'b0, lim};
  endfunction

  // one element against the zero base and the chosen base
  function automatic mode64_t feed64(mode64_t s, logic [63:0] v, logic [63:0] lim);
    mode64_t r;
    r = s;
    if (!near64(64'd0, v, lim)) begin
      if (!s.found) begin
        r.base  = v;
        r.found = 1'b1;
      end else if (!near64(s.base, v, lim)) begin
        r.covered = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic mode32_t feed32(mode32_t s, logic [31:0] v, logic [31:0] lim);
    mode32_t r;
    r = s;
    if (v > lim) begin
      if (!s.found) begin
        r.base  = v;
        r.found = 1'b1;
      end else if (!near32(s.base, v, lim)) begin
        r.covered = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic mode16_t feed16(mode16_t s, logic [15:0] v, logic [15:0] lim);
    mode16_t r;
    r = s;
    if (v > lim) begin
      if (!s.found) begin
        r.base  = v;
        r.found = 1'b1;
      end else if (!near16(s.base, v, lim)) begin
        r.covered = 1'b0;
      end
    end
    return r;
  endfunction

  // smallest encoding that fits the line
  function automatic logic [SIZE_W-1:0] best_size(line_flags_t f);
    logic [SIZE_W-1:0] best;
    best = SIZE_W'(LINE_BYTES);
    if (f.all_zero) best = SIZE_W'(1);
    if (f.same_word && best > SIZE_W'(8)) best = SIZE_W'(8);
    if (f.same_half && best > SIZE_W'(4)) best = SIZE_W'(4);
    for (int m = 0; m < MODES; m++) begin
      if (f.covered[m] && SIZE_MODE[m] < best) best = SIZE_MODE[m];
    end
    return best;
  endfunction

endpackage

// File: hdl/bdisz_line_track.sv
// Per-line tracking state and per-word encoding checks
module bdisz_line_track
  import bdisz_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [63:0] word,
  output logic        last,
  output line_flags_t flags_nxt
);

  logic [COUNT_W-1:0] count_r;
  logic               all_zero_r;
  logic [63:0]        first_word_r;
  logic               same_word_r;
  logic [31:0]        first_half_r;
  logic               same_half_r;
  logic [63:0]        base64_r [N64];
  logic [31:0]        base32_r [N32];
  logic [15:0]        base16_r;
  logic [MODES-1:0]   found_r;
  logic [MODES-1:0]   covered_r;

  logic [63:0]        first_w;
  logic [31:0]        first_h;
  logic               same_word_nxt;
  logic               same_half_nxt;
  logic               all_zero_nxt;
  mode64_t            st64_nxt [N64];
  mode32_t            st32_nxt [N32];
  mode16_t            st16_nxt;
  logic [MODES-1:0]   found_nxt;
  logic [MODES-1:0]   covered_nxt;

  assign last = (count_r == COUNT_W'(WORDS_PER_LINE - 1));

  // first word of the line is taken from the bus directly
  assign first_w = (count_r == '0) ? word : first_word_r;
  assign first_h = (count_r == '0) ? word[31:0] : first_half_r;

  // zero, repeated-word and repeated-half checks
  assign all_zero_nxt  = all_zero_r && (word == 64'd0);
  assign same_word_nxt = same_word_r && (word == first_w);
  assign same_half_nxt = same_half_r && (word[31:0] == first_h) && (word[63:32] == first_h);

  // two-base delta checks, elements of a word in address order
  always_comb begin
    mode32_t s32;
    mode16_t s16;
    for (int i = 0; i < N64; i++) begin
      st64_nxt[i] = feed64('{base: base64_r[i], found: found_r[MODE_B8_D1 + i],
                             covered: covered_r[MODE_B8_D1 + i]}, word, LIM64[i]);
    end
    for (int i = 0; i < N32; i++) begin
      s32 = '{base: base32_r[i], found: found_r[MODE_B4_D1 + i],
              covered: covered_r[MODE_B4_D1 + i]};
      s32 = feed32(s32, word[31:0], LIM32[i]);
      st32_nxt[i] = feed32(s32, word[63:32], LIM32[i]);
    end
    s16 = '{base: base16_r, found: found_r[MODE_B2_D1], covered: covered_r[MODE_B2_D1]};
    s16 = feed16(s16, word[15:0], LIM16);
    s16 = feed16(s16, word[31:16], LIM16);
    s16 = feed16(s16, word[47:32], LIM16);
    st16_nxt = feed16(s16, word[63:48], LIM16);
  end

  // gather mode flags
  always_comb begin
    for (int i = 0; i < N64; i++) begin
      found_nxt[MODE_B8_D1 + i]   = st64_nxt[i].found;
      covered_nxt[MODE_B8_D1 + i] = st64_nxt[i].covered;
    end
    for (int i = 0; i < N32; i++) begin
      found_nxt[MODE_B4_D1 + i]   = st32_nxt[i].found;
      covered_nxt[MODE_B4_D1 + i] = st32_nxt[i].covered;
    end
    found_nxt[MODE_B2_D1]   = st16_nxt.found;
    covered_nxt[MODE_B2_D1] = st16_nxt.covered;
  end

  assign flags_nxt = '{all_zero: all_zero_nxt, same_word: same_word_nxt,
                       same_half: same_half_nxt, covered: covered_nxt};

  // control state, back to line start after the last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      all_zero_r  <= 1'b1;
      same_word_r <= 1'b1;
      same_half_r <= 1'b1;
      found_r     <= '0;
      covered_r   <= '1;
    end else if (step) begin
      if (last) begin
        count_r     <= '0;
        all_zero_r  <= 1'b1;
        same_word_r <= 1'b1;
        same_half_r <= 1'b1;
        found_r     <= '0;
        covered_r   <= '1;
      end else begin
        count_r     <= count_r + COUNT_W'(1);
        all_zero_r  <= all_zero_nxt;
        same_word_r <= same_word_nxt;
        same_half_r <= same_half_nxt;
        found_r     <= found_nxt;
        covered_r   <= covered_nxt;
      end
    end
  end

  // stored values, read only once the line count or their found flags say they were written
  always_ff @(posedge clk) begin
    if (step) begin
      first_word_r <= first_w;
      first_half_r <= first_h;
      for (int i = 0; i < N64; i++) base64_r[i] <= st64_nxt[i].base;
      for (int i = 0; i < N32; i++) base32_r[i] <= st32_nxt[i].base;
      base16_r <= st16_nxt.base;
    end
  end

endmodule

// File: hdl/bdi_line_compressed_size_unit.sv
// Top level of the BDI line compressed size unit
// Takes a cache line as WORDS_PER_LINE 64-bit words, one transfer per word, lowest
// address first, and after the last word gives the smallest Base-Delta-Immediate size
// of the line in bytes (1 up to 8 * WORDS_PER_LINE). One word is taken every cycle
// unless the unit stalls input: each word is held in the input register, then the zero,
// repeat and six two-base delta checks update the line state in one pass, and the size
// of a line is then written into the output register.
// Lines follow each other with no gap; the unit stalls input only while a finished
// size waits in the output register and the next line's last word is ready behind it.
module bdi_line_compressed_size_unit
  import bdisz_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_data_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] out_compressed_bytes
);

  logic [63:0]       word_r;
  logic              word_vld_r;
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_bytes_r;
  logic              advance;
  logic              last;
  line_flags_t       flags_nxt;

  // the held word moves on unless it ends a line and the result slot is blocked
  assign advance  = word_vld_r && (!last || !out_valid_r || !out_stall);
  assign in_stall = word_vld_r && !advance;

  bdisz_line_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .word      (word_r),
    .last      (last),
    .flags_nxt (flags_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      word_vld_r <= 1'b1;
    end else if (advance) begin
      word_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) word_r <= in_data_word;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) out_bytes_r <= best_size(flags_nxt);
  end

  assign out_valid            = out_valid_r;
  assign out_compressed_bytes = out_bytes_r;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the BDI line compressed size unit
`timescale 1ns / 100ps

module testbench;
  import bdisz_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 500;
  localparam int LINES_PER_PHASE = 45;
  localparam int PRESSURE_LINES = 12;
  localparam int HOLD_PERIOD = 80;
  localparam int HOLD_CYCLES = 50;

  typedef enum int {
    PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE, PH_PRESSURE
  } tb_phase_t;

  typedef enum int {
    LINE_ZERO, LINE_REPEAT_WORD, LINE_REPEAT_HALF,
    LINE_DELTA64, LINE_DELTA32, LINE_DELTA16, LINE_NOISE
  } line_kind_t;

  // line with extreme words: most negative distance, limits and one past them
  localparam logic [63:0] EDGE_LINE [8] = '{
    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0100,
    64'h8000_0000_0000_FFFF, 64'h0123_4567_89AB_CDEF,
    64'hFFFF_FFFF_0000_0001, 64'h0000_FFFF_FFFF_0000
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       in_data_word = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SIZE_W-1:0] out_compressed_bytes;

  // stimulus and expected sizes
  logic [63:0]       word_q [$];
  logic [SIZE_W-1:0] size_q [$];
  int                mismatch_cnt = 0;

  tb_phase_t test_phase = PH_FREE;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_cyc = 0;
  int        quiet_cycles = 0;

  // line tracking state of the size predictor
  int unsigned line_words;
  bit          line_zero;
  bit          line_same_word;
  bit          line_same_half;
  logic [63:0] line_first_word;
  logic [31:0] line_first_half;
  logic [63:0] pair_base [MODES];
  bit          pair_found [MODES];
  bit          pair_fits [MODES];

  bdi_line_compressed_size_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_word         (in_data_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_compressed_bytes (out_compressed_bytes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned elem_bytes(int m);
    case (m)
      MODE_B8_D1, MODE_B8_D2, MODE_B8_D4: return 8;
      MODE_B4_D1, MODE_B4_D2: return 4;
      default: return 2;
    endcase
  endfunction

  function automatic int unsigned delta_bytes(int m);
    case (m)
      MODE_B8_D1, MODE_B4_D1, MODE_B2_D1: return 1;
      MODE_B8_D2, MODE_B4_D2: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic logic [63:0] delta_limit(int m);
    return (64'd1 << (8 * delta_bytes(m))) - 64'd1;
  endfunction

  function automatic logic [63:0] elem_mask(int unsigned eb);
    return (eb == 8) ? '1 : ((64'd1 << (8 * eb)) - 64'd1);
  endfunction

  // modulo 2^64 difference read as signed, magnitude only
  function automatic logic [63:0] wrapped_dist(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63] ? (64'd0 - d) : d;
  endfunction

  task automatic clear_line();
    line_words = 0;
    line_zero = 1'b1;
    line_same_word = 1'b1;
    line_same_half = 1'b1;
    line_first_word = '0;
    line_first_half = '0;
    for (int m = 0; m < MODES; m++) begin
      pair_base[m] = '0;
      pair_found[m] = 1'b0;
      pair_fits[m] = 1'b1;
    end
  endtask

  // fold one accepted word into the line; on the last word queue the size
  task automatic absorb_word(input logic [63:0] w);
    logic [63:0] elem;
    logic [63:0] lim;
    int unsigned eb;
    int unsigned best;
    int unsigned enc;
    if (line_words == 0) begin
      line_first_word = w;
      line_first_half = w[31:0];
    end
    if (w != 64'd0) line_zero = 1'b0;
    if (w != line_first_word) line_same_word = 1'b0;
    if (w[31:0] != line_first_half || w[63:32] != line_first_half) line_same_half = 1'b0;
    for (int m = 0; m < MODES; m++) begin
      eb = elem_bytes(m);
      lim = delta_limit(m);
      for (int k = 0; k < 8 / eb; k++) begin
        elem = (w >> (8 * eb * k)) & elem_mask(eb);
        if (wrapped_dist(64'd0, elem) > lim) begin
          if (!pair_found[m]) begin
            pair_base[m] = elem;
            pair_found[m] = 1'b1;
          end else if (wrapped_dist(pair_base[m], elem) > lim) begin
            pair_fits[m] = 1'b0;
          end
        end
      end
    end
    line_words++;
    if (line_words == WORDS_PER_LINE) begin
      best = LINE_BYTES;
      if (line_zero) best = 1;
      if (line_same_word && best > 8) best = 8;
      if (line_same_half && best > 4) best = 4;
      for (int m = 0; m < MODES; m++) begin
        enc = delta_bytes(m) * (LINE_BYTES / elem_bytes(m)) + 2 * elem_bytes(m);
        if (pair_fits[m] && enc < best) best = enc;
      end
      size_q.push_back(SIZE_W'(best));
      clear_line();
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // value within or just past the limit around a base
  function automatic logic [63:0] near_elem(logic [63:0] base, logic [63:0] lim, bit allow_neg);
    logic [63:0] d;
    case ($urandom_range(0, 5))
      0: d = lim;
      1: d = lim + 64'd1;
      2: d = 64'd0;
      default: d = {$urandom, $urandom} & lim;
    endcase
    if (allow_neg && $urandom_range(0, 1) == 1) return base - d;
    return base + d;
  endfunction

  function automatic line_kind_t random_kind();
    case ($urandom_range(0, 9))
      0: return LINE_ZERO;
      1: return LINE_REPEAT_WORD;
      2: return LINE_REPEAT_HALF;
      3, 4: return LINE_DELTA64;
      5, 6: return LINE_DELTA32;
      7: return LINE_DELTA16;
      default: return LINE_NOISE;
    endcase
  endfunction

  // one line of shaped words, sometimes with one bit flipped in one word
  task automatic queue_line(input line_kind_t kind);
    logic [63:0] base;
    logic [63:0] lim;
    logic [63:0] w;
    logic [31:0] half;
    int          broken;
    base = {$urandom, $urandom};
    half = $urandom;
    broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, WORDS_PER_LINE - 1) : -1;
    case (kind)
      LINE_DELTA64: begin
        case ($urandom_range(0, 2))
          0: lim = delta_limit(MODE_B8_D1);
          1: lim = delta_limit(MODE_B8_D2);
          default: lim = delta_limit(MODE_B8_D4);
        endcase
        if ($urandom_range(0, 7) == 0) base = 64'h8000_0000_0000_0000;
      end
      LINE_DELTA32: begin
        lim = ($urandom_range(0, 1) == 0) ? delta_limit(MODE_B4_D1) : delta_limit(MODE_B4_D2);
        base = {32'd0, half};
      end
      default: begin
        lim = delta_limit(MODE_B2_D1);
        base = {48'd0, half[15:0]};
      end
    endcase
    for (int i = 0; i < WORDS_PER_LINE; i++) begin
      case (kind)
        LINE_ZERO: w = '0;
        LINE_REPEAT_WORD: w = base;
        LINE_REPEAT_HALF: w = {half, half};
        LINE_DELTA64:
          w = ($urandom_range(0, 2) == 0) ? near_elem(64'd0, lim, 1'b1)
                                           : near_elem(base, lim, 1'b1);
        LINE_DELTA32:
          for (int k = 0; k < 2; k++) begin
            w[32*k +: 32] = 32'(($urandom_range(0, 2) == 0) ? near_elem(64'd0, lim, 1'b0)
                                                              : near_elem(base, lim, 1'b1));
          end
        LINE_DELTA16:
          for (int k = 0; k < 4; k++) begin
            w[16*k +: 16] = 16'(($urandom_range(0, 2) == 0) ? near_elem(64'd0, lim, 1'b0)
                                                              : near_elem(base, lim, 1'b1));
          end
        default:
          case ($urandom_range(0, 4))
            0: w = {$urandom, $urandom};
            1: w = 64'h8000_0000_0000_0000;
            2: w = base + 64'h8000_0000_0000_0000;
            3: w = '0;
            default: w = near_elem(64'd0, 64'hFF, 1'b1);
          endcase
      endcase
      if (i == broken) w ^= 64'd1 << $urandom_range(0, 63);
      word_q.push_back(w);
    end
  endtask

  task automatic set_phase(input tb_phase_t p);
    test_phase = p;
    case (p)
      PH_SEND_IDLE: begin send_idle_pct = 68; recv_stall_pct = 0; end
      PH_RECV_STALL: begin send_idle_pct = 0; recv_stall_pct = 68; end
      PH_BOTH_IDLE: begin send_idle_pct = 16; recv_stall_pct = 16; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // wait at the falling edge until every queued word has been transferred
  task automatic wait_words_sent();
    while (word_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic run_phase(input tb_phase_t p, input int lines);
    set_phase(p);
    for (int i = 0; i < lines; i++) queue_line(random_kind());
    wait_words_sent();
  endtask

  // input driver: a word stays put while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_word(in_data_word);
      if (!in_valid || !in_stall) begin
        if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_word <= word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with long hold-offs during the pressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cyc <= 0;
    end else if (test_phase == PH_PRESSURE) begin
      hold_cyc <= (hold_cyc == HOLD_PERIOD - 1) ? 0 : hold_cyc + 1;
      out_stall <= (hold_cyc < HOLD_CYCLES);
    end else begin
      hold_cyc <= 0;
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (size_q.size() == 0) begin
        note_mismatch($sformatf("size %0d arrived with no line pending", out_compressed_bytes));
      end else begin
        if (out_compressed_bytes !== size_q[0])
          note_mismatch($sformatf("size mismatch: expected %0d, got %0d",
                                  size_q[0], out_compressed_bytes));
        void'(size_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bdi_line_compressed_size_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int drain_cycles;
    clear_line();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed lines: all zero, all ones, extreme words
    set_phase(PH_FREE);
    queue_line(LINE_ZERO);
    for (int i = 0; i < WORDS_PER_LINE; i++) word_q.push_back('1);
    for (int i = 0; i < WORDS_PER_LINE; i++) word_q.push_back(EDGE_LINE[i % 8]);
    wait_words_sent();

    run_phase(PH_FREE, LINES_PER_PHASE);
    run_phase(PH_SEND_IDLE, LINES_PER_PHASE);
    run_phase(PH_RECV_STALL, LINES_PER_PHASE);
    run_phase(PH_BOTH_IDLE, LINES_PER_PHASE);
    run_phase(PH_PRESSURE, PRESSURE_LINES);
    set_phase(PH_FREE);

    // let the last sizes come out before the final check
    drain_cycles = 0;
    while (size_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (8) @(negedge clk);
    if (size_q.size() != 0)
      note_mismatch($sformatf("%0d line sizes never arrived", size_q.size()));

    if (mismatch_cnt == 0) begin
      $display("bdi_line_compressed_size_unit: match");
    end else begin
      $display("bdi_line_compressed_size_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bdisz_pkg.sv
hdl/bdisz_line_track.sv
hdl/bdi_line_compressed_size_unit.sv
tb/testbench.sv
